/* rtl/core/fair_share_run_queue_unit_macros.svh */
// ---------------------------------------------------------------------------
// Run queue assertion macros
// Shared concurrent assertion wrappers on clk_i / rst_ni.
// ---------------------------------------------------------------------------
`ifndef FAIR_SHARE_RUN_QUEUE_UNIT_MACROS_SVH
`define FAIR_SHARE_RUN_QUEUE_UNIT_MACROS_SVH

// property must hold at every clock edge out of reset
`define FRQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen
`define FRQ_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

/* rtl/core/frq_pkg.sv */
// ---------------------------------------------------------------------------
// Run queue package
// Shared constants, codes and controller/datapath types.
// ---------------------------------------------------------------------------
package frq_pkg;

  localparam int unsigned QueueDepthDef = 64;
  localparam int unsigned ThreadBitsDef = 8;

  localparam int unsigned OpW    = 2;
  localparam int unsigned KeyW   = 32;
  localparam int unsigned TidW   = 8;
  localparam int unsigned StatW  = 2;
  localparam int unsigned CntW   = 7;
  localparam int unsigned SliceW = 32;
  localparam int unsigned CfgW   = 32;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [OpW-1:0] OP_INSERT = 2'd0;
  localparam logic [OpW-1:0] OP_REMOVE = 2'd1;
  localparam logic [OpW-1:0] OP_PICK   = 2'd2;

  localparam logic [StatW-1:0] ST_DONE      = 2'd0;
  localparam logic [StatW-1:0] ST_OVERWRITE = 2'd1;
  localparam logic [StatW-1:0] ST_FULL      = 2'd2;
  localparam logic [StatW-1:0] ST_MISS      = 2'd3;

  localparam logic [CfgIdxW-1:0] CFG_BASE_LATENCY    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_LATENCY_THREADS = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MIN_GRANULARITY = 2'd2;

  localparam logic [31:0]     BaseLatencyRst    = 32'd20000000;
  localparam logic [CntW-1:0] LatencyThreadsRst = 7'd5;
  localparam logic [31:0]     MinGranularityRst = 32'd4000000;

  typedef struct packed {
    logic load;
    logic scan;
    logic apply;
    logic slice;
    logic finish;
  } frq_cmd_t;

  typedef struct packed {
    logic scan_done;
  } frq_stat_t;

endpackage

/* rtl/core/frq_if.sv */
// ---------------------------------------------------------------------------
// Run queue channels
// Valid/ready channels for operations and results.
// ---------------------------------------------------------------------------
interface frq_in_if import frq_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [OpW-1:0]         op;
  logic signed [KeyW-1:0] key;
  logic [TidW-1:0]        thread_id;

  modport source (output valid, op, key, thread_id, input ready);
  modport sink   (input valid, op, key, thread_id, output ready);
endinterface

interface frq_out_if import frq_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [StatW-1:0]       status;
  logic [TidW-1:0]        picked_thread;
  logic signed [KeyW-1:0] picked_key;
  logic [CntW-1:0]        queued_count;
  logic signed [KeyW-1:0] min_runtime;
  logic [SliceW-1:0]      time_slice;

  modport source (output valid, status, picked_thread, picked_key, queued_count,
                  min_runtime, time_slice, input ready);
  modport sink   (input valid, status, picked_thread, picked_key, queued_count,
                  min_runtime, time_slice, output ready);
endinterface

/* rtl/core/frq_ctrl.sv */
// ---------------------------------------------------------------------------
// Run queue controller
// Sequences load, table scan, update, slice and result transfer.
// ---------------------------------------------------------------------------
module frq_ctrl import frq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  frq_stat_t stat_i,
  output frq_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_APPLY, S_SLICE, S_FINISH, S_OUT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    unique case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_SCAN;
      S_SCAN:   if (stat_i.scan_done) state_d = S_APPLY;
      S_APPLY:  state_d = S_SLICE;
      S_SLICE:  state_d = S_FINISH;
      S_FINISH: begin
        state_d     = S_OUT;
        out_valid_d = 1'b1;
      end
      S_OUT: begin
        if (out_ready_i) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b0;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign cmd_o.load    = in_valid_i && (state_q == S_IDLE);
  assign cmd_o.scan    = (state_q == S_SCAN);
  assign cmd_o.apply   = (state_q == S_APPLY);
  assign cmd_o.slice   = (state_q == S_SLICE);
  assign cmd_o.finish  = (state_q == S_FINISH);

endmodule

/* rtl/core/frq_datapath.sv */
// ---------------------------------------------------------------------------
// Run queue datapath
// Entry memory, valid bits, scan comparators, update and slice arithmetic.
// ---------------------------------------------------------------------------
`include "fair_share_run_queue_unit_macros.svh"

module frq_datapath import frq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef,
  parameter int unsigned THREAD_BITS = ThreadBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  frq_cmd_t               cmd_i,
  output frq_stat_t              stat_o,
  input  logic [OpW-1:0]         op_i,
  input  logic signed [KeyW-1:0] key_i,
  input  logic [TidW-1:0]        tid_i,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxW-1:0]     cfg_idx_i,
  input  logic [CfgW-1:0]        cfg_data_i,
  output logic [StatW-1:0]       status_o,
  output logic [TidW-1:0]        picked_thread_o,
  output logic signed [KeyW-1:0] picked_key_o,
  output logic [CntW-1:0]        queued_count_o,
  output logic signed [KeyW-1:0] min_runtime_o,
  output logic [SliceW-1:0]      time_slice_o
);

  localparam int unsigned AW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned IW   = AW + 1;
  localparam int unsigned CW   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned MW   = (CW > CntW) ? CW : CntW;
  localparam int unsigned SW   = (THREAD_BITS < TidW) ? THREAD_BITS : TidW;
  localparam int unsigned PW   = 32 + CW;

  logic [KeyW-1:0]        keys_mem [QUEUE_DEPTH];
  logic [SW-1:0]          thr_mem  [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] valid_q;

  logic [31:0]     base_q, gran_q;
  logic [CntW-1:0] lat_q;

  logic [OpW-1:0]         op_q;
  logic signed [KeyW-1:0] key_q;
  logic [SW-1:0]          tid_q;

  logic [IW-1:0]          idx_q;
  logic                   rd_vld_q;
  logic [AW-1:0]          cmp_idx_q;
  logic signed [KeyW-1:0] rd_key_q;
  logic [SW-1:0]          rd_thr_q;

  logic                   match_found_q, free_found_q, min_found_q;
  logic [AW-1:0]          match_idx_q, free_idx_q, min_idx_q;
  logic signed [KeyW-1:0] min_key_q;
  logic [SW-1:0]          min_thr_q;

  logic [CW-1:0]          count_q;
  logic signed [KeyW-1:0] last_min_q;
  logic [StatW-1:0]       status_q;
  logic [SW-1:0]          pthr_q;
  logic signed [KeyW-1:0] pkey_q;
  logic [PW-1:0]          prod_q;
  logic [SliceW-1:0]      slice_q;

  logic          issue;
  logic          key_we, thr_we;
  logic [AW-1:0] wr_addr;

  assign issue = cmd_i.scan && (idx_q < IW'(QUEUE_DEPTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BaseLatencyRst;
      lat_q  <= LatencyThreadsRst;
      gran_q <= MinGranularityRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BASE_LATENCY:    base_q <= cfg_data_i;
        CFG_LATENCY_THREADS: lat_q  <= cfg_data_i[CntW-1:0];
        CFG_MIN_GRANULARITY: gran_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // memory write port
  always_comb begin
    key_we  = 1'b0;
    thr_we  = 1'b0;
    wr_addr = free_idx_q;
    if (cmd_i.apply && op_q == OP_INSERT) begin
      if (match_found_q) begin
        thr_we  = 1'b1;
        wr_addr = match_idx_q;
      end else if (free_found_q) begin
        key_we = 1'b1;
        thr_we = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_we) keys_mem[wr_addr] <= key_q;
    if (thr_we) thr_mem[wr_addr]  <= tid_q;
    if (issue) begin
      rd_key_q <= keys_mem[idx_q[AW-1:0]];
      rd_thr_q <= thr_mem[idx_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= op_i;
      key_q <= key_i;
      tid_q <= SW'(tid_i);
    end
    if (issue) cmp_idx_q <= idx_q[AW-1:0];
    if (cmd_i.slice) prod_q <= PW'(gran_q) * PW'(count_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q       <= '0;
      count_q       <= '0;
      last_min_q    <= '0;
      idx_q         <= '0;
      rd_vld_q      <= 1'b0;
      match_found_q <= 1'b0;
      free_found_q  <= 1'b0;
      min_found_q   <= 1'b0;
      match_idx_q   <= '0;
      free_idx_q    <= '0;
      min_idx_q     <= '0;
      min_key_q     <= '0;
      min_thr_q     <= '0;
      status_q      <= ST_MISS;
      pthr_q        <= '0;
      pkey_q        <= '0;
      slice_q       <= '0;
    end else begin
      if (cmd_i.load) begin
        idx_q         <= '0;
        rd_vld_q      <= 1'b0;
        match_found_q <= 1'b0;
        free_found_q  <= 1'b0;
        min_found_q   <= 1'b0;
      end
      if (cmd_i.scan) begin
        rd_vld_q <= issue;
        if (issue) idx_q <= idx_q + IW'(1);
        if (rd_vld_q) begin
          if (valid_q[cmp_idx_q] && rd_key_q == key_q && !match_found_q) begin
            match_found_q <= 1'b1;
            match_idx_q   <= cmp_idx_q;
          end
          if (!valid_q[cmp_idx_q] && !free_found_q) begin
            free_found_q <= 1'b1;
            free_idx_q   <= cmp_idx_q;
          end
          if (valid_q[cmp_idx_q] && (!min_found_q || rd_key_q < min_key_q)) begin
            min_found_q <= 1'b1;
            min_idx_q   <= cmp_idx_q;
            min_key_q   <= rd_key_q;
            min_thr_q   <= rd_thr_q;
          end
        end
      end
      if (cmd_i.apply) begin
        pthr_q   <= '0;
        pkey_q   <= '0;
        status_q <= ST_MISS;
        unique case (op_q)
          OP_INSERT: begin
            if (match_found_q) begin
              status_q <= ST_OVERWRITE;
            end else if (!free_found_q) begin
              status_q <= ST_FULL;
            end else begin
              valid_q[free_idx_q] <= 1'b1;
              count_q             <= count_q + CW'(1);
              status_q            <= ST_DONE;
            end
          end
          OP_REMOVE: begin
            if (match_found_q) begin
              valid_q[match_idx_q] <= 1'b0;
              count_q              <= count_q - CW'(1);
              status_q             <= ST_DONE;
            end
          end
          OP_PICK: begin
            if (min_found_q) begin
              valid_q[min_idx_q] <= 1'b0;
              count_q            <= count_q - CW'(1);
              last_min_q         <= min_key_q;
              pthr_q             <= min_thr_q;
              pkey_q             <= min_key_q;
              status_q           <= ST_DONE;
            end
          end
          default: ;
        endcase
      end
      if (cmd_i.finish) begin
        if (MW'(count_q) > MW'(lat_q)) begin
          slice_q <= (|prod_q[PW-1:32]) ? '1 : prod_q[31:0];
        end else begin
          slice_q <= base_q;
        end
      end
    end
  end

  assign stat_o.scan_done   = (idx_q == IW'(QUEUE_DEPTH)) && !rd_vld_q;

  assign status_o        = status_q;
  assign picked_thread_o = TidW'(pthr_q);
  assign picked_key_o    = pkey_q;
  assign queued_count_o  = CntW'(MW'(count_q));
  assign min_runtime_o   = last_min_q;
  assign time_slice_o    = slice_q;

  `FRQ_ASSERT(a_count_tracks_valid, $countones(valid_q) == 32'(count_q), "count mismatch")
  `FRQ_ASSERT(a_read_needs_scan, rd_vld_q |-> $past(cmd_i.scan), "read without scan")
  `FRQ_ASSERT_NEVER(a_load_while_busy, cmd_i.load && (cmd_i.scan || cmd_i.apply), "load overlap")

endmodule

/* rtl/core/fair_share_run_queue_unit.sv */
// ---------------------------------------------------------------------------
// Fair share run queue
// Key-ordered run queue with insert, remove and pick-minimum operations.
// ---------------------------------------------------------------------------
// From input transfer to result valid, each operation goes through these
// steps: the entry table is a memory that is scanned one entry per cycle
// to find the matching key, the lowest free slot and the smallest key,
// then the APPLY state updates the table, the SLICE state multiplies the
// granularity by the count and the FINISH state saturates the slice.
// One operation is in flight at a time; a new one is taken once the result
// has been transferred.
module fair_share_run_queue_unit import frq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef,
  parameter int unsigned THREAD_BITS = ThreadBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  frq_in_if.sink             in_i,
  frq_out_if.source          out_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  frq_cmd_t  cmd;
  frq_stat_t stat;

  frq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  frq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .THREAD_BITS (THREAD_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .op_i            (in_i.op),
    .key_i           (in_i.key),
    .tid_i           (in_i.thread_id),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .status_o        (out_o.status),
    .picked_thread_o (out_o.picked_thread),
    .picked_key_o    (out_o.picked_key),
    .queued_count_o  (out_o.queued_count),
    .min_runtime_o   (out_o.min_runtime),
    .time_slice_o    (out_o.time_slice)
  );

endmodule
